FILE: hw/rtl/positional_list_engine_assert.svh
// assertion macros shared by the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine assertion failed");

// antecedent implies consequent in the following cycle
`define PLE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine assertion failed");

`endif

FILE: hw/rtl/ple_pkg.sv
// types, codes and constants of the positional list engine
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int DIV_W    = CNT_W + 1;
   localparam int POS_W    = 16;
   localparam int VAL_W    = 32;
   localparam int STEP_W   = $clog2(POS_W);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_PRINT  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NODEL = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [POS_W-1:0] position;
      logic signed [VAL_W-1:0] value_in;
   } req_item_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value_out;
      logic [1:0]              status;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] rem;
   } mod_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_MOVE,
      S_COMMIT,
      S_RESP,
      S_PRD,
      S_PWAIT
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ple_mod.sv
// iterative remainder unit, one quotient bit per cycle
`default_nettype none

module ple_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ple_pkg::POS_W-1:0]   dividend,
   input  wire logic [ple_pkg::DIV_W-1:0]   divisor,
   output ple_pkg::mod_result_type          result
);
   import ple_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    trial_sub;
   logic [DIV_W-1:0]  rem_step;

   always_comb begin
      trial     = {rem_ff, num_ff[POS_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      rem_step  = (trial >= {1'b0, div_ff}) ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         div_in = divisor;
         // short cut when the position already lies inside the walk
         if (dividend < {{(POS_W-DIV_W){1'b0}}, divisor}) begin
            rem_in  = dividend[DIV_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            num_in  = dividend;
            rem_in  = '0;
            cnt_in  = STEP_W'(POS_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         num_in = {num_ff[POS_W-2:0], 1'b0};
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// top level of the positional list engine: sequencer, list memory, output register
`default_nettype none
`include "positional_list_engine_assert.svh"

// Ordered list of up to CAPACITY signed 32-bit values, empty after reset, held in
// one single-port-write ram with registered read. One item is worked on at a time;
// req_stall is high from acceptance until its last result has been loaded into the
// output register, which then lets the next item in while that result waits.
// Insert and delete first reduce the position modulo count+1 in an iterative unit,
// with a short cut when it is already below count+1. The entries past the position
// then move one slot per cycle through the ram (count-position moves for insert,
// count-position-1 for delete); when the last move is written back and the mover
// is empty, a commit state writes the new value on insert and updates the count,
// then a response state follows. An insert into a full list skips the divider and
// the moves, a failed delete only the moves. A print gives one result per cycle
// while the output is not stalled, limited by the one ram read port. Reset clears
// the state, the entry count and the valid flags; the ram is not swept.
module positional_list_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ple_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ple_pkg::rsp_item_type      rsp_item
);
   import ple_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [1:0]        status_ff, status_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  mv_rd_ff, mv_rd_in;
   logic [CNT_W-1:0]  mv_left_ff, mv_left_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              out_free;
   logic              load_rsp;
   logic              print_last;
   logic              mod_start;
   logic [POS_W-1:0]  mod_dividend;
   logic [DIV_W-1:0]  mod_divisor;
   mod_result_type    mod_res;
   logic [CNT_W-1:0]  mod_k;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [VAL_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [VAL_W-1:0]  ram_rd_data;
   logic [CNT_W-1:0]  count_m1;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_m1  = count_ff - 1'b1;
   assign print_last = ({1'b0, idx_ff} == count_m1);
   assign mod_k     = mod_res.rem[CNT_W-1:0];

   // negative position counts as zero
   assign mod_dividend = req_item.position[POS_W-1] ? '0 : req_item.position;
   assign mod_divisor  = {1'b0, count_ff} + 1'b1;

   ple_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (mod_divisor),
      .result   (mod_res)
   );

   ple_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_item.req_type)
                  OP_INSERT: state_in = ({1'b0, count_ff} >= DIV_W'(CAPACITY)) ? S_RESP : S_MOD;
                  OP_DELETE: state_in = S_MOD;
                  OP_PRINT:  state_in = (count_ff == '0) ? S_RESP : S_PRD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_MOD: begin
            if (mod_res.done) begin
               if (op_ff == OP_DELETE && mod_k >= count_ff) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            if (mv_left_ff == '0 && !pend_valid_ff) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_PRD:    state_in = S_PWAIT;
         S_PWAIT: begin
            if (out_free && print_last) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // memory, divider and output register controls
   always_comb begin
      mod_start   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mv_rd_ff;
      load_rsp    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            mod_start = accept && (req_item.req_type == OP_DELETE ||
                        (req_item.req_type == OP_INSERT &&
                         {1'b0, count_ff} < DIV_W'(CAPACITY)));
         end
         S_MOVE: begin
            ram_wr_en = pend_valid_ff;
            ram_rd_en = (mv_left_ff != '0);
         end
         S_COMMIT: begin
            ram_wr_en   = (op_ff == OP_INSERT);
            ram_wr_addr = k_ff[IDX_W-1:0];
            ram_wr_data = val_ff;
         end
         S_RESP: load_rsp = out_free;
         S_PRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff;
         end
         S_PWAIT: begin
            load_rsp    = out_free;
            // prefetch the next entry as this one goes out
            ram_rd_en   = out_free && !print_last;
            ram_rd_addr = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      mv_rd_in      = mv_rd_ff;
      mv_left_in    = mv_left_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_item.req_type;
               val_in    = req_item.value_in;
               idx_in    = '0;
               status_in = ST_OK;
               if (req_item.req_type == OP_INSERT &&
                   {1'b0, count_ff} >= DIV_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else if (req_item.req_type == OP_PRINT && count_ff == '0) begin
                  status_in = ST_EMPTY;
               end
            end
         end
         S_MOD: begin
            if (mod_res.done) begin
               k_in = mod_k;
               if (op_ff == OP_INSERT) begin
                  mv_left_in = count_ff - mod_k;
                  mv_rd_in   = count_m1[IDX_W-1:0];
               end else if (mod_k >= count_ff) begin
                  status_in = ST_NODEL;
               end else begin
                  mv_left_in = count_m1 - mod_k;
                  mv_rd_in   = IDX_W'(mod_k + 1'b1);
               end
            end
         end
         S_MOVE: begin
            if (mv_left_ff != '0) begin
               pend_valid_in = 1'b1;
               mv_left_in    = mv_left_ff - 1'b1;
               if (op_ff == OP_INSERT) begin
                  pend_addr_in = mv_rd_ff + 1'b1;
                  mv_rd_in     = mv_rd_ff - 1'b1;
               end else begin
                  pend_addr_in = mv_rd_ff - 1'b1;
                  mv_rd_in     = mv_rd_ff + 1'b1;
               end
            end
         end
         S_COMMIT: begin
            count_in = (op_ff == OP_INSERT) ? count_ff + 1'b1 : count_m1;
         end
         S_RESP: begin
            if (load_rsp) begin
               rsp_in.value_out = '0;
               rsp_in.status    = status_ff;
               rsp_in.last      = 1'b1;
               rsp_valid_in     = 1'b1;
            end
         end
         S_PWAIT: begin
            if (load_rsp) begin
               rsp_in.value_out = ram_rd_data;
               rsp_in.status    = ST_OK;
               rsp_in.last      = print_last;
               rsp_valid_in     = 1'b1;
               idx_in           = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      val_ff       <= val_in;
      k_ff         <= k_in;
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      mv_rd_ff     <= mv_rd_in;
      mv_left_ff   <= mv_left_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `PLE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, (count_ff <= CNT_W'(CAPACITY)))
   `PLE_ASSERT_IMP(a_pend_in_move, clock, reset, pend_valid_ff, state_ff == S_MOVE)
   `PLE_ASSERT_IMP(a_mod_done_in_mod, clock, reset, mod_res.done, state_ff == S_MOD)
   `PLE_ASSERT_NXT(a_commit_to_resp, clock, reset, state_ff == S_COMMIT, state_ff == S_RESP)
   `PLE_ASSERT_NXT(a_count_only_commit, clock, reset, state_ff != S_COMMIT, $stable(count_ff))

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the positional list engine
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 294;
   localparam int PHASE_LEN    = 60;
   localparam int TAIL_ITEMS   = 30;
   localparam int SETTLE_CYCLES = 100;
   localparam int STUCK_LIMIT  = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   rsp_item_type oldest_rsp;

   // mirror of the list contents
   logic signed [VAL_W-1:0] list_vals[CAPACITY];
   int                      list_len = 0;

   int failures = 0;
   int send_gap = 0;
   int hold_gap = 0;
   int stuck_cycles = 0;

   positional_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // work out the results of one request and update the mirrored list
   task automatic predict_list_op(input req_item_type r);
      int           spot;
      rsp_item_type rsp;
      spot = r.position[POS_W-1] ? 0 : int'({1'b0, r.position[POS_W-2:0]});
      spot = spot % (list_len + 1);
      rsp.value_out = '0;
      rsp.status    = ST_OK;
      rsp.last      = 1'b1;
      case (r.req_type)
         OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = list_len; i > spot; i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[spot] = r.value_in;
               list_len++;
            end
            expected_rsps.push_back(rsp);
         end
         OP_DELETE: begin
            if (spot >= list_len) begin
               rsp.status = ST_NODEL;
            end else begin
               for (int i = spot; i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i+1];
               list_len--;
            end
            expected_rsps.push_back(rsp);
         end
         OP_PRINT: begin
            if (list_len == 0) begin
               rsp.status = ST_EMPTY;
               expected_rsps.push_back(rsp);
            end else begin
               for (int i = 0; i < list_len; i++) begin
                  rsp.value_out = list_vals[i];
                  rsp.last      = (i == list_len - 1);
                  expected_rsps.push_back(rsp);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_req(input logic [1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
      req_item_type r;
      r.req_type = op;
      r.position = pos;
      r.value_in = val;
      pending_reqs.push_back(r);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_list_op(req_item);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 11);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_item  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result item with nothing expected: value_out %0d status %0d last %0d",
                      rsp_item.value_out, rsp_item.status, rsp_item.last);
               failures++;
            end else begin
               oldest_rsp = expected_rsps.pop_front();
               if (rsp_item.value_out !== oldest_rsp.value_out) begin
                  $error("value_out: expected %0d, actual %0d",
                         oldest_rsp.value_out, rsp_item.value_out);
                  failures++;
               end
               if (rsp_item.status !== oldest_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         oldest_rsp.status, rsp_item.status);
                  failures++;
               end
               if (rsp_item.last !== oldest_rsp.last) begin
                  $error("last: expected %0d, actual %0d", oldest_rsp.last, rsp_item.last);
                  failures++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap  <= hold_gap - 1;
            rsp_stall <= 1'b1;
         end else if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            hold_gap  <= $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int         made;
      int         roll;
      logic [1:0] op;
      logic [POS_W-1:0] pos;

      // empty list corner cases
      add_req(OP_PRINT,  16'd0,     32'd0);
      add_req(OP_DELETE, 16'd0,     32'd0);
      add_req(OP_DELETE, 16'hFFFB,  32'd5);
      add_req(OP_DELETE, 16'h7FFF,  32'd0);
      // inserts with extreme positions and values
      add_req(OP_INSERT, 16'd0,     32'h7FFF_FFFF);
      add_req(OP_INSERT, 16'h8000,  32'h8000_0000);
      add_req(OP_INSERT, 16'h7FFF,  32'd0);
      add_req(OP_INSERT, 16'd3,     32'hFFFF_FFFF);
      add_req(OP_INSERT, 16'hFFFF,  32'h5A5A_A5A5);
      add_req(OP_PRINT,  16'h1234,  32'hDEAD_BEEF);
      // delete at position count, then wrapping onto it, then valid ones
      add_req(OP_DELETE, 16'd5,     32'd0);
      add_req(OP_DELETE, 16'd11,    32'd0);
      add_req(OP_DELETE, 16'd4,     32'd0);
      add_req(OP_DELETE, 16'h8001,  32'd0);
      add_req(OP_UNUSED, 16'd1,     32'h1234_5678);
      add_req(OP_PRINT,  16'd0,     32'd0);
      add_req(OP_DELETE, 16'd13,    32'd0);
      add_req(OP_PRINT,  16'd0,     32'd0);

      // alternate phases that fill the list past full and drain it past empty
      made = 0;
      while (made < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll >= 97)
            op = OP_UNUSED;
         else if ((made / PHASE_LEN) % 2 == 0)
            op = roll < 72 ? OP_INSERT : (roll < 84 ? OP_DELETE : OP_PRINT);
         else
            op = roll < 15 ? OP_INSERT : (roll < 72 ? OP_DELETE : OP_PRINT);
         case ($urandom_range(0, 9))
            0, 1:    pos = 16'($urandom_range(0, 4));
            2:       pos = 16'($urandom());
            3:       pos = 16'hFFFF - 16'($urandom_range(0, 39));
            default: pos = 16'($urandom_range(0, 33));
         endcase
         add_req(op, pos, $urandom());
         if (op != OP_UNUSED)
            made++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $error("%0d result items never arrived", expected_rsps.size());
         failures++;
      end
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_ram.sv
hw/rtl/ple_mod.sv
hw/rtl/positional_list_engine.sv
test/testbench.sv
